[src/tpt_pkg.sv]
// Shared types and constants for the TLB and page table translator.
`timescale 1ns / 1ps

package tpt_pkg;

    localparam logic [1:0] OUT_TLB_HIT  = 2'd0;
    localparam logic [1:0] OUT_PT_HIT   = 2'd1;
    localparam logic [1:0] OUT_FAULT    = 2'd2;
    localparam logic [1:0] OUT_EVICT    = 2'd3;

    typedef struct packed {
        logic load;
        logic reduce;
        logic tlb_look;
        logic pt_rd;
        logic pt_chk;
        logic frm_scan;
        logic own_rd;
        logic alloc;
        logic fill_scan;
        logic fill_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic red_done;
        logic tlb_hit;
        logic tlb_last;
        logic pt_hit;
        logic frm_done;
    } stat_t;

endpackage

[src/tpt_ctrl.sv]
// Sequencer for the translator: walks lookup, fault handling and TLB fill.
`timescale 1ns / 1ps

module tpt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output tpt_pkg::cmd_t cmd,
    input  tpt_pkg::stat_t stat
);
    import tpt_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_REDUCE  = 11'b00000000010,
        S_TLB     = 11'b00000000100,
        S_PT_RD   = 11'b00000001000,
        S_PT_CHK  = 11'b00000010000,
        S_FRM     = 11'b00000100000,
        S_OWN     = 11'b00001000000,
        S_ALLOC   = 11'b00010000000,
        S_FILL    = 11'b00100000000,
        S_FILL_WR = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (stat.red_done)
                begin
                    state_next = S_TLB;
                end
            end
            S_TLB:
            begin
                cmd.tlb_look = 1'b1;
                if (stat.tlb_hit)
                begin
                    state_next = S_DONE;
                end
                else if (stat.tlb_last)
                begin
                    state_next = S_PT_RD;
                end
            end
            S_PT_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_PT_CHK;
            end
            S_PT_CHK:
            begin
                cmd.pt_chk = 1'b1;
                state_next = stat.pt_hit ? S_FILL : S_FRM;
            end
            S_FRM:
            begin
                cmd.frm_scan = 1'b1;
                if (stat.frm_done)
                begin
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                cmd.own_rd = 1'b1;
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_scan = 1'b1;
                if (stat.tlb_last)
                begin
                    state_next = S_FILL_WR;
                end
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TLB) && stat.tlb_hit |=> done)
        else $error("TLB hit did not finish");
    a_fault_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PT_CHK) && !stat.pt_hit |=> (state_reg == S_FRM))
        else $error("fault did not start frame scan");

endmodule

[src/tpt_datapath.sv]
// Storage and scan datapath: TLB, page table, frame table and access clock.
`timescale 1ns / 1ps

module tpt_datapath #(
    parameter int TLB_ENTRIES = 32,
    parameter int FRAME_COUNT = 128,
    parameter int PAGE_COUNT  = 256,
    parameter int STAMP_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tpt_pkg::cmd_t  cmd,
    output tpt_pkg::stat_t stat,
    input  logic [15:0]    virtual_address,
    output logic [6:0]     frame_number,
    output logic [7:0]     byte_offset,
    output logic [14:0]    physical_address,
    output logic [1:0]     outcome,
    output logic [7:0]     evicted_page
);
    import tpt_pkg::*;

    localparam int TW = $clog2(TLB_ENTRIES);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int PW = $clog2(PAGE_COUNT);

    logic [7:0]             page_reg;
    logic [7:0]             offset_reg;
    logic [FW-1:0]          frame_reg;
    logic [1:0]             outcome_reg;
    logic [7:0]             victim_reg;
    logic [STAMP_WIDTH-1:0] clock_reg;

    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [7:0]             tlb_tag_reg   [TLB_ENTRIES];
    logic [FW-1:0]          tlb_frame_reg [TLB_ENTRIES];
    logic [STAMP_WIDTH-1:0] tlb_stamp_reg [TLB_ENTRIES];

    logic [PAGE_COUNT-1:0]  pt_valid_reg;
    logic [PAGE_COUNT-1:0]  pt_present_reg;
    logic [FW-1:0]          pt_frame_mem  [PAGE_COUNT];
    logic [FW-1:0]          pt_rd_reg;

    logic [FRAME_COUNT-1:0] in_use_reg;
    logic [STAMP_WIDTH-1:0] fstamp_mem    [FRAME_COUNT];
    logic [7:0]             owner_mem     [FRAME_COUNT];
    logic [STAMP_WIDTH-1:0] fstamp_rd_reg;
    logic [7:0]             owner_rd_reg;

    logic [TW-1:0]          ti_reg;
    logic [FW-1:0]          fi_reg;
    logic                   iss_reg;
    logic                   cmpv_reg;
    logic [FW-1:0]          cmp_idx_reg;
    logic                   free_found_reg;
    logic                   mfirst_reg;
    logic [FW-1:0]          fsel_reg;
    logic [FW-1:0]          msel_reg;
    logic [STAMP_WIDTH-1:0] fmin_reg;
    logic                   evict_reg;

    logic                   ffound_reg;
    logic                   tfirst_reg;
    logic [TW-1:0]          fslot_reg;
    logic [TW-1:0]          tsel_reg;
    logic [STAMP_WIDTH-1:0] tmin_reg;

    logic [PW-1:0]          pidx;
    logic                   take_free;
    logic                   take_min;
    logic [FW-1:0]          frame_pick;
    logic                   fill_kill;
    logic                   fill_v;
    logic                   take_slot;
    logic                   take_tmin;
    logic [TW-1:0]          slot;

    assign pidx          = page_reg[PW-1:0];
    assign stat.red_done = ({1'b0, page_reg} < 9'(PAGE_COUNT));
    assign stat.tlb_hit  = tlb_valid_reg[ti_reg] && (tlb_tag_reg[ti_reg] == page_reg);
    assign stat.tlb_last = (ti_reg == TW'(TLB_ENTRIES - 1));
    assign stat.pt_hit   = pt_valid_reg[pidx] & pt_present_reg[pidx];
    assign stat.frm_done = cmpv_reg && (cmp_idx_reg == FW'(FRAME_COUNT - 1));

    assign take_free  = cmd.frm_scan && cmpv_reg && !in_use_reg[cmp_idx_reg] && !free_found_reg;
    assign take_min   = cmd.frm_scan && cmpv_reg && (mfirst_reg || (fstamp_rd_reg < fmin_reg));
    assign frame_pick = free_found_reg ? fsel_reg : msel_reg;
    assign fill_kill  = evict_reg && (tlb_tag_reg[ti_reg] == victim_reg);
    assign fill_v     = tlb_valid_reg[ti_reg] && !fill_kill;
    assign take_slot  = cmd.fill_scan && !fill_v && !ffound_reg;
    assign take_tmin  = cmd.fill_scan && (tfirst_reg || (tlb_stamp_reg[ti_reg] < tmin_reg));
    assign slot       = ffound_reg ? fslot_reg : tsel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ti_reg         <= '0;
            fi_reg         <= '0;
            iss_reg        <= 1'b0;
            cmpv_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            mfirst_reg     <= 1'b1;
            evict_reg      <= 1'b0;
            ffound_reg     <= 1'b0;
            tfirst_reg     <= 1'b1;
            tlb_valid_reg  <= '0;
            pt_valid_reg   <= '0;
            pt_present_reg <= '0;
            in_use_reg     <= '0;
            clock_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ti_reg <= '0;
            end
            if (cmd.tlb_look && !stat.tlb_hit && !stat.tlb_last)
            begin
                ti_reg <= ti_reg + 1'b1;
            end
            if (cmd.pt_chk)
            begin
                ti_reg         <= '0;
                fi_reg         <= '0;
                iss_reg        <= 1'b1;
                cmpv_reg       <= 1'b0;
                free_found_reg <= 1'b0;
                mfirst_reg     <= 1'b1;
                evict_reg      <= 1'b0;
                ffound_reg     <= 1'b0;
                tfirst_reg     <= 1'b1;
            end
            if (cmd.frm_scan)
            begin
                cmpv_reg <= iss_reg;
                if (iss_reg)
                begin
                    if (fi_reg == FW'(FRAME_COUNT - 1))
                    begin
                        iss_reg <= 1'b0;
                    end
                    else
                    begin
                        fi_reg <= fi_reg + 1'b1;
                    end
                end
                if (take_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (take_min)
                begin
                    mfirst_reg <= 1'b0;
                end
            end
            if (cmd.own_rd)
            begin
                evict_reg <= !free_found_reg;
            end
            if (cmd.alloc)
            begin
                if (evict_reg)
                begin
                    pt_present_reg[owner_rd_reg[PW-1:0]] <= 1'b0;
                end
                in_use_reg[frame_reg] <= 1'b1;
                pt_valid_reg[pidx]    <= 1'b1;
                pt_present_reg[pidx]  <= 1'b1;
            end
            if (cmd.fill_scan)
            begin
                tlb_valid_reg[ti_reg] <= fill_v;
                if (take_slot)
                begin
                    ffound_reg <= 1'b1;
                end
                if (take_tmin)
                begin
                    tfirst_reg <= 1'b0;
                end
                if (!stat.tlb_last)
                begin
                    ti_reg <= ti_reg + 1'b1;
                end
            end
            if (cmd.fill_wr)
            begin
                tlb_valid_reg[slot] <= 1'b1;
            end
            if (cmd.finish && (clock_reg != '1))
            begin
                clock_reg <= clock_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg   <= virtual_address[15:8];
            offset_reg <= virtual_address[7:0];
            victim_reg <= '0;
        end
        if (cmd.reduce && !stat.red_done)
        begin
            page_reg <= page_reg - 8'(PAGE_COUNT);
        end
        if (cmd.tlb_look && stat.tlb_hit)
        begin
            tlb_stamp_reg[ti_reg] <= clock_reg;
            frame_reg             <= tlb_frame_reg[ti_reg];
            outcome_reg           <= OUT_TLB_HIT;
        end
        if (cmd.pt_rd)
        begin
            pt_rd_reg <= pt_frame_mem[pidx];
        end
        if (cmd.pt_chk && stat.pt_hit)
        begin
            frame_reg   <= pt_rd_reg;
            outcome_reg <= OUT_PT_HIT;
        end
        if (cmd.frm_scan)
        begin
            if (iss_reg)
            begin
                fstamp_rd_reg <= fstamp_mem[fi_reg];
                cmp_idx_reg   <= fi_reg;
            end
            if (take_free)
            begin
                fsel_reg <= cmp_idx_reg;
            end
            if (take_min)
            begin
                fmin_reg <= fstamp_rd_reg;
                msel_reg <= cmp_idx_reg;
            end
        end
        if (cmd.own_rd)
        begin
            frame_reg    <= frame_pick;
            owner_rd_reg <= owner_mem[frame_pick];
        end
        if (cmd.alloc)
        begin
            fstamp_mem[frame_reg] <= clock_reg;
            owner_mem[frame_reg]  <= page_reg;
            pt_frame_mem[pidx]    <= frame_reg;
            victim_reg            <= evict_reg ? owner_rd_reg : 8'd0;
            outcome_reg           <= evict_reg ? OUT_EVICT : OUT_FAULT;
        end
        if (take_slot)
        begin
            fslot_reg <= ti_reg;
        end
        if (take_tmin)
        begin
            tmin_reg <= tlb_stamp_reg[ti_reg];
            tsel_reg <= ti_reg;
        end
        if (cmd.fill_wr)
        begin
            tlb_tag_reg[slot]   <= page_reg;
            tlb_frame_reg[slot] <= frame_reg;
            tlb_stamp_reg[slot] <= clock_reg;
        end
    end

    assign frame_number     = 7'(frame_reg);
    assign byte_offset      = offset_reg;
    assign physical_address = {frame_number, offset_reg};
    assign outcome          = outcome_reg;
    assign evicted_page     = victim_reg;

endmodule

[src/tlb_page_table_translator.sv]
// A request first reduces the page by subtracting PAGE_COUNT, then scans the TLB for a hit.
// On a miss, a page table hit goes to the TLB fill scan; a fault first scans the frame table.
// The serial scans over the TLB entries and the frame table go one entry per cycle.
// One request at a time; start is taken again the cycle after the done strobe.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset clears all valid, present and in-use bits and the access clock at once.
`timescale 1ns / 1ps

module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = 32,
    parameter int FRAME_COUNT = 128,
    parameter int PAGE_COUNT  = 256,
    parameter int STAMP_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [15:0] virtual_address,
    output logic [6:0]  frame_number,
    output logic [7:0]  byte_offset,
    output logic [14:0] physical_address,
    output logic [1:0]  outcome,
    output logic [7:0]  evicted_page
);
    import tpt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    tpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_COUNT  (PAGE_COUNT),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .virtual_address  (virtual_address),
        .frame_number     (frame_number),
        .byte_offset      (byte_offset),
        .physical_address (physical_address),
        .outcome          (outcome),
        .evicted_page     (evicted_page)
    );

endmodule
